// ===== rtl/hhbs_pkg.sv =====
package hhbs_pkg;

  // Line break bytes
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // Partial terminator progress codes
  localparam logic [2:0] MP_NONE    = 3'd0;
  localparam logic [2:0] MP_CR      = 3'd1;
  localparam logic [2:0] MP_LF      = 3'd2;
  localparam logic [2:0] MP_CRLF    = 3'd3;
  localparam logic [2:0] MP_CRLFCR  = 3'd4;

  // Section codes
  localparam logic SECT_HEADER = 1'b0;
  localparam logic SECT_BODY   = 1'b1;

  // Status codes
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_NO_END = 1'b1;

  // Most output words one input byte can produce
  localparam int unsigned MAX_BURST = 4;

  // One output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       section;
    logic       header_end;
    logic       out_last;
    logic       status;
  } res_t;

endpackage

// ===== rtl/hhbs_in_if.sv =====
interface hhbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/hhbs_out_if.sv =====
interface hhbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       section;
  logic       header_end;
  logic       out_last;
  logic       status;

  modport source (output valid, output out_byte, output section, output header_end,
                  output out_last, output status, input ready);
  modport sink   (input valid, input out_byte, input section, input header_end,
                  input out_last, input status, output ready);
endinterface

// ===== rtl/http_header_body_splitter.sv =====
// HTTP response header/body splitter.
// rx carries the raw response one byte per word, in_last on the final byte.
// tx carries header words (section 0), then body words (section 1). The
// header is normalized: each CR/LF run becomes CR LF and the terminator
// word expands to CR LF CR LF with header_end on the final LF. If a message
// ends with no terminator, one word with status 1 and out_last 1 is sent
// and everything sent for that message must be dropped.
// Each word passes from the burst register into the output register before
// it leaves on tx. One input byte yields zero to four words; while tx is not
// stalled, a byte that yields one word sustains one byte per cycle, and a
// byte that yields several words holds rx while the burst register drains
// into the output register one word per cycle.
// Reset clears the parse state and the valid flags of the burst and output registers.
// When tx stalls, the output register holds its word, the burst register
// fills, and rx ready drops until the burst has drained.
module http_header_body_splitter (
  input  logic              clk,
  input  logic              rst,
  hhbs_in_if.sink           rx,
  hhbs_out_if.source        tx
);

  // parse state
  logic [2:0] match_progress, match_progress_next;
  logic       in_body, in_body_next;
  logic       pending_break, pending_break_next;

  // burst register: up to four words of one byte
  hhbs_pkg::res_t slot [hhbs_pkg::MAX_BURST];
  hhbs_pkg::res_t slot_next [hhbs_pkg::MAX_BURST];
  logic [1:0] burst_top;       // index of the final word in the burst
  logic [1:0] burst_idx;
  logic       burst_valid;
  logic [2:0] burst_n;
  logic [1:0] burst_top_next;

  // output register
  hhbs_pkg::res_t out_word;
  logic           out_valid;

  logic rx_fire, load_out, burst_done, hit;
  logic [2:0] mp;

  assign load_out   = burst_valid && (!out_valid || tx.ready);
  assign burst_done = load_out && (burst_idx == burst_top);
  assign rx.ready   = !burst_valid || burst_done;
  assign rx_fire    = rx.valid && rx.ready;
  assign burst_top_next = burst_n[1:0] - 2'd1;

  // parse one byte: next state and the words it produces
  always_comb begin
    mp = (match_progress > hhbs_pkg::MP_CRLFCR) ? hhbs_pkg::MP_NONE : match_progress;
    hit = 1'b0;
    burst_n = 3'd0;
    match_progress_next = mp;
    in_body_next = in_body;
    pending_break_next = pending_break;
    for (int i = 0; i < hhbs_pkg::MAX_BURST; i++) begin
      slot_next[i] = '0;
    end

    if (in_body) begin
      slot_next[0] = '{rx.in_byte, hhbs_pkg::SECT_BODY, 1'b0, rx.in_last, hhbs_pkg::STAT_OK};
      burst_n = 3'd1;
    end else begin
      if (rx.in_byte == hhbs_pkg::BYTE_CR) begin
        if (mp == hhbs_pkg::MP_CR || mp == hhbs_pkg::MP_CRLFCR) begin
          hit = 1'b1;
        end else begin
          match_progress_next = (mp == hhbs_pkg::MP_CRLF) ? hhbs_pkg::MP_CRLFCR
                                                          : hhbs_pkg::MP_CR;
        end
        pending_break_next = 1'b1;
      end else if (rx.in_byte == hhbs_pkg::BYTE_LF) begin
        if (mp == hhbs_pkg::MP_LF || mp == hhbs_pkg::MP_CRLF ||
            mp == hhbs_pkg::MP_CRLFCR) begin
          hit = 1'b1;
        end else begin
          match_progress_next = (mp == hhbs_pkg::MP_CR) ? hhbs_pkg::MP_CRLF
                                                        : hhbs_pkg::MP_LF;
        end
        pending_break_next = 1'b1;
      end else begin
        // ordinary byte closes any pending break run
        if (pending_break) begin
          slot_next[0] = '{hhbs_pkg::BYTE_CR, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                           hhbs_pkg::STAT_OK};
          slot_next[1] = '{hhbs_pkg::BYTE_LF, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                           hhbs_pkg::STAT_OK};
          slot_next[2] = '{rx.in_byte, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                           hhbs_pkg::STAT_OK};
          burst_n = 3'd3;
        end else begin
          slot_next[0] = '{rx.in_byte, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                           hhbs_pkg::STAT_OK};
          burst_n = 3'd1;
        end
        pending_break_next = 1'b0;
        match_progress_next = hhbs_pkg::MP_NONE;
      end

      // terminator: CR LF CR LF, header_end on the final LF
      if (hit) begin
        slot_next[0] = '{hhbs_pkg::BYTE_CR, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                         hhbs_pkg::STAT_OK};
        slot_next[1] = '{hhbs_pkg::BYTE_LF, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                         hhbs_pkg::STAT_OK};
        slot_next[2] = '{hhbs_pkg::BYTE_CR, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                         hhbs_pkg::STAT_OK};
        slot_next[3] = '{hhbs_pkg::BYTE_LF, hhbs_pkg::SECT_HEADER, 1'b1, rx.in_last,
                         hhbs_pkg::STAT_OK};
        burst_n = 3'd4;
        in_body_next = 1'b1;
        pending_break_next = 1'b0;
        match_progress_next = hhbs_pkg::MP_NONE;
      end else if (rx.in_last) begin
        // message ended inside the header: single error word
        slot_next[0] = '{8'h00, hhbs_pkg::SECT_HEADER, 1'b0, 1'b1, hhbs_pkg::STAT_NO_END};
        slot_next[1] = '0;
        slot_next[2] = '0;
        burst_n = 3'd1;
      end
    end

    // end of message returns to the header phase
    if (rx.in_last) begin
      match_progress_next = hhbs_pkg::MP_NONE;
      in_body_next = 1'b0;
      pending_break_next = 1'b0;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      match_progress <= hhbs_pkg::MP_NONE;
      in_body <= 1'b0;
      pending_break <= 1'b0;
    end else if (rx_fire) begin
      match_progress <= match_progress_next;
      in_body <= in_body_next;
      pending_break <= pending_break_next;
    end
  end

  // burst register control
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      burst_idx <= 2'd0;
    end else if (rx_fire) begin
      burst_valid <= (burst_n != 3'd0);
      burst_idx <= 2'd0;
    end else if (burst_done) begin
      burst_valid <= 1'b0;
      burst_idx <= 2'd0;
    end else if (load_out) begin
      burst_idx <= burst_idx + 2'd1;
    end
  end

  // burst payload
  always_ff @(posedge clk) begin
    if (rx_fire) begin
      slot <= slot_next;
      burst_top <= burst_top_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word <= slot[burst_idx];
    end
  end

  assign tx.valid      = out_valid;
  assign tx.out_byte   = out_word.out_byte;
  assign tx.section    = out_word.section;
  assign tx.header_end = out_word.header_end;
  assign tx.out_last   = out_word.out_last;
  assign tx.status     = out_word.status;

endmodule

// ===== tb/sv/hhbs_split_checker.sv =====
// Watches both channels of the splitter, models the header/body split of every
// accepted input byte and compares each output word with the oldest expected one.
module hhbs_split_checker (
  input  logic clk,
  input  logic rst,
  hhbs_in_if   rx,
  hhbs_out_if  tx,
  output int   errors,
  output int   pending,
  output int   words_checked,
  output int   invalid_msgs
);

  // Words still owed by the block, oldest first
  hhbs_pkg::res_t expected_words[$];

  // Model state: terminator progress, body phase, open CR/LF run
  logic [2:0] term_prog;
  logic       body_phase;
  logic       break_pending;

  int err_cnt;
  int word_cnt;
  int invalid_cnt;

  function automatic hhbs_pkg::res_t mk_word(logic [7:0] b, logic sect, logic hend,
                                             logic last, logic stat);
    hhbs_pkg::res_t w;
    w.out_byte   = b;
    w.section    = sect;
    w.header_end = hend;
    w.out_last   = last;
    w.status     = stat;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  // Works out the words that one input byte produces and queues them
  task automatic split_byte(input logic [7:0] b, input logic last);
    hhbs_pkg::res_t burst[$];
    logic [2:0]     prog;
    logic           hit;
    hit  = 1'b0;
    prog = (term_prog > hhbs_pkg::MP_CRLFCR) ? hhbs_pkg::MP_NONE : term_prog;

    if (body_phase) begin
      // body bytes pass straight through
      burst.push_back(mk_word(b, hhbs_pkg::SECT_BODY, 1'b0, last, hhbs_pkg::STAT_OK));
    end else if (b == hhbs_pkg::BYTE_CR) begin
      if (prog == hhbs_pkg::MP_CR || prog == hhbs_pkg::MP_CRLFCR) hit = 1'b1;
      else prog = (prog == hhbs_pkg::MP_CRLF) ? hhbs_pkg::MP_CRLFCR : hhbs_pkg::MP_CR;
      break_pending = 1'b1;
    end else if (b == hhbs_pkg::BYTE_LF) begin
      if (prog == hhbs_pkg::MP_LF || prog == hhbs_pkg::MP_CRLF ||
          prog == hhbs_pkg::MP_CRLFCR) hit = 1'b1;
      else prog = (prog == hhbs_pkg::MP_CR) ? hhbs_pkg::MP_CRLF : hhbs_pkg::MP_LF;
      break_pending = 1'b1;
    end else begin
      // ordinary header byte closes any open run with one CR LF
      if (break_pending) begin
        burst.push_back(mk_word(hhbs_pkg::BYTE_CR, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                                hhbs_pkg::STAT_OK));
        burst.push_back(mk_word(hhbs_pkg::BYTE_LF, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                                hhbs_pkg::STAT_OK));
        break_pending = 1'b0;
      end
      burst.push_back(mk_word(b, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0, hhbs_pkg::STAT_OK));
      prog = hhbs_pkg::MP_NONE;
    end

    if (!body_phase) begin
      // terminator: header always ends in CR LF CR LF
      if (hit) begin
        burst.push_back(mk_word(hhbs_pkg::BYTE_CR, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                                hhbs_pkg::STAT_OK));
        burst.push_back(mk_word(hhbs_pkg::BYTE_LF, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                                hhbs_pkg::STAT_OK));
        burst.push_back(mk_word(hhbs_pkg::BYTE_CR, hhbs_pkg::SECT_HEADER, 1'b0, 1'b0,
                                hhbs_pkg::STAT_OK));
        burst.push_back(mk_word(hhbs_pkg::BYTE_LF, hhbs_pkg::SECT_HEADER, 1'b1, last,
                                hhbs_pkg::STAT_OK));
        body_phase    = 1'b1;
        break_pending = 1'b0;
        prog          = hhbs_pkg::MP_NONE;
      end
      term_prog = prog;
      // message ended inside the header: one error word replaces the rest
      if (last && !hit) begin
        burst = {mk_word(8'h00, hhbs_pkg::SECT_HEADER, 1'b0, 1'b1, hhbs_pkg::STAT_NO_END)};
      end
    end

    if (last) begin
      term_prog     = hhbs_pkg::MP_NONE;
      body_phase    = 1'b0;
      break_pending = 1'b0;
    end
    foreach (burst[i]) expected_words.push_back(burst[i]);
  endtask

  always @(posedge clk) begin : monitor
    hhbs_pkg::res_t got;
    hhbs_pkg::res_t want;
    if (rst) begin
      expected_words.delete();
      term_prog     = hhbs_pkg::MP_NONE;
      body_phase    = 1'b0;
      break_pending = 1'b0;
    end else begin
      if (rx.valid && rx.ready) split_byte(rx.in_byte, rx.in_last);

      if (tx.valid && tx.ready) begin
        got = {tx.out_byte, tx.section, tx.header_end, tx.out_last, tx.status};
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d, byte %02h", word_cnt,
                                    got.out_byte));
        end else begin
          want = expected_words.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("word %0d out_byte %02h, expected %02h",
                                      word_cnt, got.out_byte, want.out_byte));
          if (got.section !== want.section)
            report_mismatch($sformatf("word %0d section %b, expected %b",
                                      word_cnt, got.section, want.section));
          if (got.header_end !== want.header_end)
            report_mismatch($sformatf("word %0d header_end %b, expected %b",
                                      word_cnt, got.header_end, want.header_end));
          if (got.out_last !== want.out_last)
            report_mismatch($sformatf("word %0d out_last %b, expected %b",
                                      word_cnt, got.out_last, want.out_last));
          if (got.status !== want.status)
            report_mismatch($sformatf("word %0d status %b, expected %b",
                                      word_cnt, got.status, want.status));
          if (want.status == hhbs_pkg::STAT_NO_END) invalid_cnt++;
        end
        word_cnt++;
      end
    end
    // publish after the edge so the top never races the update
    errors        <= err_cnt;
    pending       <= expected_words.size();
    words_checked <= word_cnt;
    invalid_msgs  <= invalid_cnt;
  end

endmodule

// ===== tb/sv/http_header_body_splitter_tb.sv =====
module http_header_body_splitter_tb;

  typedef logic [7:0] byte_q_t[$];

  localparam int RANDOM_ITEMS   = 120;
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;

  hhbs_in_if  rx_if ();
  hhbs_out_if tx_if ();

  http_header_body_splitter dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  int errors;
  int pending;
  int words_checked;
  int invalid_msgs;

  hhbs_split_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .rx            (rx_if),
    .tx            (tx_if),
    .errors        (errors),
    .pending       (pending),
    .words_checked (words_checked),
    .invalid_msgs  (invalid_msgs)
  );

  byte_q_t msg;
  int      bytes_sent;
  int      msgs_sent;
  bit      gaps_off;
  int      hold_reqs;
  int      holds_done;
  int      idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (gaps_off || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.in_byte <= b;
    rx_if.in_last <= last;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    msgs_sent++;
  endtask

  // Header text: never CR or LF, extremes favored
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = 8'h00;
      1: b = 8'hFF;
      default: begin
        do b = 8'($urandom_range(0, 255));
        while (b == hhbs_pkg::BYTE_CR || b == hhbs_pkg::BYTE_LF);
      end
    endcase
    return b;
  endfunction

  function automatic void add_text(int n);
    repeat (n) msg.push_back(text_byte());
  endfunction

  // Line break run that stops short of a terminator
  function automatic void add_break();
    case ($urandom_range(0, 4))
      0: msg.push_back(hhbs_pkg::BYTE_CR);
      1: msg.push_back(hhbs_pkg::BYTE_LF);
      2: begin msg.push_back(hhbs_pkg::BYTE_CR); msg.push_back(hhbs_pkg::BYTE_LF); end
      3: begin msg.push_back(hhbs_pkg::BYTE_LF); msg.push_back(hhbs_pkg::BYTE_CR); end
      default: begin
        msg.push_back(hhbs_pkg::BYTE_CR);
        msg.push_back(hhbs_pkg::BYTE_LF);
        msg.push_back(hhbs_pkg::BYTE_CR);
      end
    endcase
  endfunction

  function automatic void add_terminator();
    case ($urandom_range(0, 2))
      0: begin msg.push_back(hhbs_pkg::BYTE_CR); msg.push_back(hhbs_pkg::BYTE_CR); end
      1: begin msg.push_back(hhbs_pkg::BYTE_LF); msg.push_back(hhbs_pkg::BYTE_LF); end
      default: begin
        msg.push_back(hhbs_pkg::BYTE_CR); msg.push_back(hhbs_pkg::BYTE_LF);
        msg.push_back(hhbs_pkg::BYTE_CR); msg.push_back(hhbs_pkg::BYTE_LF);
      end
    endcase
  endfunction

  // Raw bytes, line breaks made frequent
  function automatic void add_raw(int n, int break_pct);
    int p;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < break_pct / 2) msg.push_back(hhbs_pkg::BYTE_CR);
      else if (p < break_pct) msg.push_back(hhbs_pkg::BYTE_LF);
      else msg.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // kind < 60 well formed, < 75 no terminator, < 90 noise, else single byte
  function automatic void build_msg(int kind);
    int lines;
    msg.delete();
    lines = $urandom_range(1, 3);
    if (kind < 75) begin
      for (int i = 0; i < lines; i++) begin
        add_text($urandom_range(1, 6));
        if (i < lines - 1) add_break();
      end
      if (kind < 60) begin
        add_terminator();
        if ($urandom_range(0, 9) != 0) add_raw($urandom_range(1, 8), 25);
      end else if ($urandom_range(0, 1) == 1) begin
        add_break();
      end
    end else if (kind < 90) begin
      add_raw($urandom_range(1, 10), 40);
    end else begin
      msg.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Receiver: random stalls, stretches of steady ready, one long hold on request
  initial begin : receiver
    int idle;
    int run;
    tx_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (holds_done != hold_reqs) begin
        holds_done++;
        tx_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      idle = $urandom_range(0, 99);
      if (idle < 45) idle = 0;
      else if (idle < 85) idle = $urandom_range(1, 3);
      else if (idle < 95) idle = $urandom_range(4, 10);
      else idle = $urandom_range(15, 30);
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 6);
      if (idle > 0) begin
        tx_if.ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      tx_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int directed_bytes;
    int pressure_at;
    rst           <= 1'b1;
    rx_if.valid   <= 1'b0;
    rx_if.in_byte <= 8'h00;
    rx_if.in_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: error on plain byte and on lone CR, zero byte with terminator
    // on the last byte, LF LF with CR in body, CR LF CR LF after a closed run,
    // message ending in a partial terminator
    msg = {8'h41};
    send_msg();
    msg = {hhbs_pkg::BYTE_CR};
    send_msg();
    msg = {8'h00, hhbs_pkg::BYTE_CR, hhbs_pkg::BYTE_CR};
    send_msg();
    msg = {8'hFF, hhbs_pkg::BYTE_LF, hhbs_pkg::BYTE_LF, hhbs_pkg::BYTE_CR, 8'h80};
    send_msg();
    msg = {8'h48, hhbs_pkg::BYTE_CR, hhbs_pkg::BYTE_LF, 8'h78, hhbs_pkg::BYTE_CR,
           hhbs_pkg::BYTE_LF, hhbs_pkg::BYTE_CR, hhbs_pkg::BYTE_LF, 8'h62};
    send_msg();
    msg = {8'h61, hhbs_pkg::BYTE_CR, hhbs_pkg::BYTE_LF, hhbs_pkg::BYTE_CR};
    send_msg();
    directed_bytes = bytes_sent;

    // Random messages; one batch runs gap free into a long receiver hold
    pressure_at = msgs_sent + $urandom_range(2, 6);
    while (bytes_sent < directed_bytes + RANDOM_ITEMS) begin
      if (msgs_sent == pressure_at) begin
        hold_reqs++;
        wait (holds_done == hold_reqs);
        gaps_off = 1'b1;
        repeat (3) begin
          build_msg(0);
          send_msg();
        end
        gaps_off = 1'b0;
      end else begin
        build_msg($urandom_range(0, 99));
        send_msg();
      end
    end

    // Drain
    rx_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d messages (%0d bytes) with random stalls and one %0d-cycle hold.",
             msgs_sent, bytes_sent, LONG_HOLD);
    $display("Checked %0d output words; %0d messages ended with no header terminator.",
             words_checked, invalid_msgs);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hhbs_pkg.sv
rtl/hhbs_in_if.sv
rtl/hhbs_out_if.sv
rtl/http_header_body_splitter.sv
tb/sv/hhbs_split_checker.sv
tb/sv/http_header_body_splitter_tb.sv
